// ===== sv/fixed_point_log2_exp2_converter_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the log2 / exp2 converter
// Shared concurrent assertion forms, clocked on aclk and idle during reset.
// ---------------------------------------------------------------------------
`ifndef FIXED_POINT_LOG2_EXP2_CONVERTER_UNIT_ASSERT_SVH
`define FIXED_POINT_LOG2_EXP2_CONVERTER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define FPLE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FPLE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/fple_pkg.sv =====
// ---------------------------------------------------------------------------
// fple_pkg
// Shared types, default parameters and build-time table generators.
// ---------------------------------------------------------------------------
package fple_pkg;

    localparam int LOG_FRAC_BITS_DEF = 8;
    localparam int LIN_IN_BITS_DEF   = 16;
    localparam int LIN_OUT_BITS_DEF  = 16;

    localparam int VALUE_W  = 17;
    localparam int RESULT_W = 32;
    localparam int ROM_N    = 33;
    localparam int LOG_GUARD = 40;

    typedef struct packed {
        logic [RESULT_W-1:0] result;
        logic                saturated;
    } result_t;

    // (a * b) >> 62 in Q62 fixed point.
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Fraction bits of log2(x) for x in [1,2) given in Q62.
    function automatic logic [63:0] log2_frac(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] f;
        x = x_in;
        f = 64'd0;
        for (int k = 0; k < LOG_GUARD; k++) begin
            x = mul_q62(x, x);
            f = f << 1;
            if (x >= (64'd1 << 63)) begin
                x = x >> 1;
                f = f | 64'd1;
            end
        end
        return f;
    endfunction

    // Integer exponent of y^32 for y in [1,2) given in Q62.
    function automatic logic [63:0] pow32_exp(input logic [63:0] y_in);
        logic [63:0] y;
        logic [63:0] e;
        y = y_in;
        e = 64'd0;
        for (int k = 0; k < 5; k++) begin
            y = mul_q62(y, y);
            e = e << 1;
            if (y >= (64'd1 << 63)) begin
                y = y >> 1;
                e = e | 64'd1;
            end
        end
        return e;
    endfunction

    // Entry of the log2 mantissa table: round(log2(1 + i/32) * 2^lfb).
    function automatic logic [63:0] log_rom_entry(input int lfb, input int i);
        logic [63:0] f;
        if (i == 0) begin
            return 64'd0;
        end
        if (i == ROM_N - 1) begin
            return 64'd1 << lfb;
        end
        f = log2_frac(64'(32 + i) << 57);
        return ((f >> (LOG_GUARD - lfb - 1)) + 64'd1) >> 1;
    endfunction

    // Entry of the 2^f table: round(2^(i/32) * 2^(lob-1)).
    function automatic logic [63:0] exp_rom_entry(input int lob, input int i);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        if (i == 0) begin
            return 64'd1 << (lob - 1);
        end
        if (i == ROM_N - 1) begin
            return 64'd1 << lob;
        end
        lo = 64'd1 << 62;
        hi = 64'd1 << 63;
        for (int k = 0; k < 64; k++) begin
            if (hi - lo > 64'd1) begin
                mid = lo + ((hi - lo) >> 1);
                if (pow32_exp(mid) >= 64'(i)) begin
                    hi = mid;
                end else begin
                    lo = mid;
                end
            end
        end
        return ((hi >> (62 - lob)) + 64'd1) >> 1;
    endfunction

endpackage

// ===== sv/fple_datapath.sv =====
// ---------------------------------------------------------------------------
// fple_datapath
// Single-pass conversion logic: leading-one normalize, table lookup, one
// shared interpolation multiplier, exponent shift and saturation.
// ---------------------------------------------------------------------------
module fple_datapath #(
    parameter int LOG_FRAC_BITS = fple_pkg::LOG_FRAC_BITS_DEF,
    parameter int LIN_IN_BITS   = fple_pkg::LIN_IN_BITS_DEF,
    parameter int LIN_OUT_BITS  = fple_pkg::LIN_OUT_BITS_DEF
) (
    input  logic                                kind,
    input  logic signed [fple_pkg::VALUE_W-1:0] value,
    output fple_pkg::result_t                   res
);

    localparam int LOG_SH = LIN_IN_BITS - 6;
    localparam int LIN_SH = LOG_FRAC_BITS - 5;
    localparam int LW     = LOG_FRAC_BITS + 1;
    localparam int EW     = LIN_OUT_BITS + 1;
    localparam int MA_W   = (LW > EW) ? LW : EW;
    localparam int MB_W   = (LOG_SH > LIN_SH) ? LOG_SH : LIN_SH;
    localparam int PW     = MA_W + MB_W + 1;
    localparam logic [32:0] LIN_CEIL = (33'd1 << LIN_IN_BITS) - 33'd1;
    localparam logic [15:0] LIN_EXP0 = 16'(LIN_OUT_BITS - 1);
    localparam logic [15:0] LIN_EXPS = 16'(LIN_OUT_BITS);

    logic [LW-1:0] log_tab [0:fple_pkg::ROM_N-1];
    logic [EW-1:0] exp_tab [0:fple_pkg::ROM_N-1];

    for (genvar g = 0; g < fple_pkg::ROM_N; g++) begin : g_rom
        localparam logic [63:0] LOG_V = fple_pkg::log_rom_entry(LOG_FRAC_BITS, g);
        localparam logic [63:0] EXP_V = fple_pkg::exp_rom_entry(LIN_OUT_BITS, g);
        assign log_tab[g] = LOG_V[LW-1:0];
        assign exp_tab[g] = EXP_V[EW-1:0];
    end

    logic                   neg;
    logic [15:0]            vmag;
    logic                   log_ceil;
    logic [16:0]            xp1;
    logic [4:0]             lead_pos;
    logic [4:0]             norm_shift;
    logic [31:0]            xnorm;
    logic [LIN_IN_BITS-2:0] mant;
    logic [4:0]             lidx;
    logic [LOG_SH-1:0]      lfr;
    logic [LW-1:0]          log_lo;
    logic [LW-1:0]          log_hi;
    logic [LW-1:0]          log_diff;

    logic [15:0]            lin_c;
    logic [LOG_FRAC_BITS-1:0] lin_f;
    logic [4:0]             eidx;
    logic [LIN_SH-1:0]      efr;
    logic [EW-1:0]          exp_lo;
    logic [EW-1:0]          exp_hi;
    logic [EW-1:0]          exp_diff;

    logic [MA_W-1:0]        mul_a;
    logic [MB_W-1:0]        mul_b;
    logic [PW-1:0]          prod;
    logic [PW-1:0]          log_interp;
    logic [PW-1:0]          lin_interp;
    logic [31:0]            log_y;
    logic [31:0]            lin_x;
    logic [15:0]            lshift;
    logic [15:0]            rshift;
    logic [63:0]            lin_wide;
    logic                   lin_sat;
    logic [31:0]            lin_res;

    assign neg  = value[fple_pkg::VALUE_W-1];
    assign vmag = value[15:0];

    // Log path: normalize value + 1 so that its leading one sits at the top.
    assign log_ceil = (33'(vmag) >= LIN_CEIL);
    assign xp1      = 17'(vmag) + 17'd1;

    always_comb begin
        lead_pos = 5'd0;
        for (int k = 0; k < 17; k++) begin
            if (xp1[k]) begin
                lead_pos = 5'(k);
            end
        end
    end

    assign norm_shift = 5'(LIN_IN_BITS - 1) - lead_pos;
    assign xnorm      = 32'(xp1) << norm_shift;
    assign mant       = xnorm[LIN_IN_BITS-2:0];
    assign lidx       = mant[LIN_IN_BITS-2 -: 5];
    assign lfr        = mant[LOG_SH-1:0];
    assign log_lo     = log_tab[{1'b0, lidx}];
    assign log_hi     = log_tab[6'({1'b0, lidx}) + 6'd1];
    assign log_diff   = log_hi - log_lo;

    // Linear path: integer part is the exponent, fraction indexes the table.
    assign lin_c    = 16'(vmag >> LOG_FRAC_BITS);
    assign lin_f    = vmag[LOG_FRAC_BITS-1:0];
    assign eidx     = lin_f[LOG_FRAC_BITS-1 -: 5];
    assign efr      = lin_f[LIN_SH-1:0];
    assign exp_lo   = exp_tab[{1'b0, eidx}];
    assign exp_hi   = exp_tab[6'({1'b0, eidx}) + 6'd1];
    assign exp_diff = exp_hi - exp_lo;

    // One multiplier serves both directions.
    assign mul_a = kind ? MA_W'(exp_diff) : MA_W'(log_diff);
    assign mul_b = kind ? MB_W'(efr) : MB_W'(lfr);
    assign prod  = PW'(mul_a) * PW'(mul_b);

    assign log_interp = (prod + (PW'(1) << (LOG_SH - 1))) >> LOG_SH;
    assign lin_interp = (prod + (PW'(1) << (LIN_SH - 1))) >> LIN_SH;

    assign log_y = 32'(log_lo) + 32'(log_interp) + (32'(lead_pos) << LOG_FRAC_BITS);
    assign lin_x = 32'(exp_lo) + 32'(lin_interp);

    assign lshift   = lin_c - LIN_EXP0;
    assign rshift   = LIN_EXP0 - lin_c;
    assign lin_wide = 64'(lin_x) << lshift[5:0];

    always_comb begin
        lin_sat = 1'b0;
        lin_res = lin_x;
        if (lin_c >= LIN_EXPS) begin
            if ((lshift > 16'd32) || (lin_wide[63:32] != 32'd0)) begin
                lin_sat = 1'b1;
                lin_res = 32'hFFFF_FFFF;
            end else begin
                lin_res = lin_wide[31:0];
            end
        end else if (lin_c < LIN_EXP0) begin
            lin_res = lin_x >> rshift[4:0];
        end
    end

    always_comb begin
        res.saturated = 1'b0;
        if (kind) begin
            if (neg) begin
                res.result = 32'd1;
            end else begin
                res.result    = lin_res;
                res.saturated = lin_sat;
            end
        end else begin
            if (neg) begin
                res.result = 32'd0;
            end else if (log_ceil) begin
                res.result = 32'(LIN_IN_BITS) << LOG_FRAC_BITS;
            end else begin
                res.result = log_y;
            end
        end
    end

endmodule

// ===== sv/fixed_point_log2_exp2_converter_unit.sv =====
// ---------------------------------------------------------------------------
// fixed_point_log2_exp2_converter_unit
// Piecewise-linear log2 / exp2 converter on a streaming interface.
// ---------------------------------------------------------------------------
// Each input beat carries a 17-bit two's complement value in s_tdata and the
// conversion kind in s_tuser: 0 maps a linear sample to a fixed-point log2
// value, 1 maps such a log value back to a linear value.
// Each input beat yields exactly one output beat: m_tdata holds the 32-bit
// result and m_tuser flags a log-to-linear result that saturated.
// An accepted beat is held in an input register, converted by one pass of
// combinational logic and captured in the output register, which drives
// m_tvalid and m_tdata. One beat is taken every cycle while the receiver
// keeps m_tready high.
// The rate is set by the single shared interpolation multiplier between the
// two registers, which finishes one beat per cycle.
// When the receiver stalls, the output beat holds and the input register
// can still take one more beat; s_tready then drops until the stall ends.
// Reset clears both valid flags; the tables are constants and need no fill.
// ---------------------------------------------------------------------------
module fixed_point_log2_exp2_converter_unit #(
    parameter int LOG_FRAC_BITS = fple_pkg::LOG_FRAC_BITS_DEF,
    parameter int LIN_IN_BITS   = fple_pkg::LIN_IN_BITS_DEF,
    parameter int LIN_OUT_BITS  = fple_pkg::LIN_OUT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [16:0] value
    input  logic [0:0]  s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] result
    output logic [0:0]  m_tuser    // [0] saturated
);

    logic                                in_vld_reg;
    logic                                in_vld_next;
    logic                                in_kind_reg;
    logic signed [fple_pkg::VALUE_W-1:0] in_value_reg;
    logic                                out_vld_reg;
    logic                                out_vld_next;
    fple_pkg::result_t                   out_data_reg;
    fple_pkg::result_t                   conv;
    logic                                in_take;
    logic                                out_load;

    assign out_load = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || out_load;
    assign in_take  = s_tvalid && s_tready;

    always_comb begin
        in_vld_next  = in_take || (in_vld_reg && !out_load);
        out_vld_next = out_load || (out_vld_reg && !m_tready);
    end

    fple_datapath #(
        .LOG_FRAC_BITS(LOG_FRAC_BITS),
        .LIN_IN_BITS  (LIN_IN_BITS),
        .LIN_OUT_BITS (LIN_OUT_BITS)
    ) u_datapath (
        .kind (in_kind_reg),
        .value(in_value_reg),
        .res  (conv)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
        if (in_take) begin
            in_kind_reg  <= s_tuser[0];
            in_value_reg <= s_tdata[fple_pkg::VALUE_W-1:0];
        end
        if (out_load) begin
            out_data_reg <= conv;
        end
    end

    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = out_data_reg.result;
    assign m_tuser[0] = out_data_reg.saturated;

`include "fixed_point_log2_exp2_converter_unit_assert.svh"

    `FPLE_ASSERT_IMP(a_sat_all_ones, m_tvalid && m_tuser[0], &m_tdata, "bad saturated value")
    `FPLE_ASSERT_IMP(a_full_stall, in_vld_reg && out_vld_reg && !m_tready, !s_tready, "taken while full")
    `FPLE_ASSERT_NXT(a_take_fills_stage, s_tvalid && s_tready, in_vld_reg, "accepted beat lost")

endmodule
